FILE: sv/ises_pkg.sv
// shared types and constants of the idle/sleep energy supervisor
package ises_pkg;

  localparam int unsigned Window     = 20;
  localparam int unsigned KindNum    = 5;
  localparam logic [9:0]  EnergyMax  = 10'd1000;
  localparam int unsigned AddrWidth  = 5;

  // reset values of the configuration registers
  localparam logic [15:0] IdleThresholdRst   = 16'd50;
  localparam logic [15:0] IdleLimitRst       = 16'd60;
  localparam logic [15:0] CircadianPeriodRst = 16'd600;
  localparam logic [15:0] CooldownTicksRst   = 16'd30;
  localparam logic [9:0]  EnergyLowRst       = 10'd200;
  localparam logic [9:0]  EnergyRearmRst     = 10'd300;
  localparam logic [9:0]  InferenceCostRst   = 10'd5;
  localparam logic [9:0]  SurgeryCostRst     = 10'd20;

  typedef enum logic [2:0] {
    CmdTick       = 3'd0,
    CmdSleepDone  = 3'd1,
    CmdSleepStart = 3'd2,
    CmdInfer      = 3'd3,
    CmdExec       = 3'd4
  } ises_cmd_e;

  typedef enum logic [2:0] {
    KindPulse       = 3'd0,
    KindLowSuccess  = 3'd1,
    KindLowEnergy   = 3'd2,
    KindIdleSleep   = 3'd3,
    KindPeriodSleep = 3'd4
  } ises_kind_e;

  typedef enum logic [2:0] {
    RegIdleThreshold   = 3'd0,
    RegIdleLimit       = 3'd1,
    RegCircadianPeriod = 3'd2,
    RegCooldownTicks   = 3'd3,
    RegEnergyLow       = 3'd4,
    RegEnergyRearm     = 3'd5,
    RegInferenceCost   = 3'd6,
    RegSurgeryCost     = 3'd7
  } ises_reg_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] load_permille;
    logic [4:0]  successes;
    logic [4:0]  evaluated;
    logic        is_surgery;
  } ises_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] energy;
    logic [4:0] success_count;
    logic [4:0] eval_count;
    logic       last;
  } ises_out_t;

  typedef struct packed {
    logic [15:0] idle_threshold;
    logic [15:0] idle_limit;
    logic [15:0] circadian_period;
    logic [15:0] cooldown_ticks;
    logic [9:0]  energy_low;
    logic [9:0]  energy_rearm;
    logic [9:0]  inference_cost;
    logic [9:0]  surgery_cost;
  } ises_cfg_t;

  // results of one tick: bit k of pend set means a result of kind k is due
  typedef struct packed {
    logic [KindNum-1:0] pend;
    logic [9:0]         energy;
    logic [4:0]         succ;
    logic [4:0]         eval;
  } ises_bundle_t;

endpackage

FILE: sv/ises_cfg.sv
// apb configuration register file
module ises_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ises_pkg::AddrWidth-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output ises_pkg::ises_cfg_t                 cfg_o
);

  ises_pkg::ises_cfg_t cfg_q, cfg_d;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        ises_pkg::RegIdleThreshold:   cfg_d.idle_threshold   = pwdata[15:0];
        ises_pkg::RegIdleLimit:       cfg_d.idle_limit       = pwdata[15:0];
        ises_pkg::RegCircadianPeriod: cfg_d.circadian_period = pwdata[15:0];
        ises_pkg::RegCooldownTicks:   cfg_d.cooldown_ticks   = pwdata[15:0];
        ises_pkg::RegEnergyLow:       cfg_d.energy_low       = pwdata[9:0];
        ises_pkg::RegEnergyRearm:     cfg_d.energy_rearm     = pwdata[9:0];
        ises_pkg::RegInferenceCost:   cfg_d.inference_cost   = pwdata[9:0];
        ises_pkg::RegSurgeryCost:     cfg_d.surgery_cost     = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ises_pkg::RegIdleThreshold:   prdata = {16'd0, cfg_q.idle_threshold};
      ises_pkg::RegIdleLimit:       prdata = {16'd0, cfg_q.idle_limit};
      ises_pkg::RegCircadianPeriod: prdata = {16'd0, cfg_q.circadian_period};
      ises_pkg::RegCooldownTicks:   prdata = {16'd0, cfg_q.cooldown_ticks};
      ises_pkg::RegEnergyLow:       prdata = {22'd0, cfg_q.energy_low};
      ises_pkg::RegEnergyRearm:     prdata = {22'd0, cfg_q.energy_rearm};
      ises_pkg::RegInferenceCost:   prdata = {22'd0, cfg_q.inference_cost};
      ises_pkg::RegSurgeryCost:     prdata = {22'd0, cfg_q.surgery_cost};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_threshold   <= ises_pkg::IdleThresholdRst;
      cfg_q.idle_limit       <= ises_pkg::IdleLimitRst;
      cfg_q.circadian_period <= ises_pkg::CircadianPeriodRst;
      cfg_q.cooldown_ticks   <= ises_pkg::CooldownTicksRst;
      cfg_q.energy_low       <= ises_pkg::EnergyLowRst;
      cfg_q.energy_rearm     <= ises_pkg::EnergyRearmRst;
      cfg_q.inference_cost   <= ises_pkg::InferenceCostRst;
      cfg_q.surgery_cost     <= ises_pkg::SurgeryCostRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/ises_core.sv
// input register, supervisor state and per-tick decision logic
module ises_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  ises_pkg::ises_in_t     item_i,
  input  ises_pkg::ises_cfg_t    cfg_i,
  input  logic                   bundle_free_i,
  output logic                   bundle_load_o,
  output ises_pkg::ises_bundle_t bundle_o
);

  logic               in_vld_q, in_vld_d;
  ises_pkg::ises_in_t in_q;

  logic [9:0]  energy_q, energy_d;
  logic        sleeping_q, sleeping_d;
  logic        low_sent_q, low_sent_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] period_q, period_d;
  logic [15:0] cooldown_q, cooldown_d;

  logic        is_tick, advance, accept;
  logic [4:0]  eval_c, succ_c;
  logic        idle;
  logic [10:0] e_up;
  logic [9:0]  e_sat, e_new;
  logic        fire_ls, fire_le, fire_is, fire_ps;
  logic [15:0] cd_base, idle_inc, per_inc, period_eff;
  logic        sleep_mid;

  assign is_tick = (in_q.cmd == ises_pkg::CmdTick);
  assign advance = in_vld_q && (!is_tick || bundle_free_i);
  assign stall_o = in_vld_q && !advance;
  assign accept  = valid_i && !stall_o;
  assign bundle_load_o = advance && is_tick;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // tick datapath
  always_comb begin
    eval_c = ({3'd0, in_q.evaluated} > 8'(ises_pkg::Window)) ?
             5'(ises_pkg::Window) : in_q.evaluated;
    succ_c = (in_q.successes > eval_c) ? eval_c : in_q.successes;
    idle   = in_q.load_permille < cfg_i.idle_threshold;

    e_up  = {1'b0, energy_q} + (sleeping_q ? 11'd10 : 11'd2);
    e_sat = (e_up > {1'b0, ises_pkg::EnergyMax}) ? ises_pkg::EnergyMax : e_up[9:0];
    if (sleeping_q) begin
      e_new = e_sat;
    end else if (idle) begin
      e_new = e_sat - 10'd1;
    end else begin
      e_new = (energy_q > 10'd3) ? energy_q - 10'd3 : 10'd0;
    end

    fire_ls = (eval_c != 5'd0) && ((8'(succ_c) * 8'd10) < 8'(eval_c)) &&
              (cooldown_q == 16'd0);
    cd_base = fire_ls ? cfg_i.cooldown_ticks : cooldown_q;

    fire_le = (e_new < cfg_i.energy_low) && !low_sent_q;

    idle_inc = (idle_q == '1) ? idle_q : idle_q + 16'd1;
    if (idle) begin
      fire_is   = (idle_inc > cfg_i.idle_limit) && !sleeping_q;
      sleep_mid = fire_is || sleeping_q;
    end else begin
      fire_is   = 1'b0;
      sleep_mid = 1'b0;
    end

    per_inc    = (period_q == '1) ? period_q : period_q + 16'd1;
    period_eff = (cfg_i.circadian_period == 16'd0) ? 16'd1 : cfg_i.circadian_period;
    fire_ps    = (per_inc >= period_eff) && !sleep_mid;
  end

  always_comb begin
    energy_d   = energy_q;
    sleeping_d = sleeping_q;
    low_sent_d = low_sent_q;
    idle_d     = idle_q;
    period_d   = period_q;
    cooldown_d = cooldown_q;
    if (advance) begin
      case (in_q.cmd)
        ises_pkg::CmdTick: begin
          energy_d   = e_new;
          cooldown_d = (cd_base != 16'd0) ? cd_base - 16'd1 : 16'd0;
          if (e_new >= cfg_i.energy_rearm) begin
            low_sent_d = 1'b0;
          end else if (fire_le) begin
            low_sent_d = 1'b1;
          end
          if (idle) begin
            idle_d = fire_is ? 16'd0 : idle_inc;
          end else begin
            idle_d = 16'd0;
          end
          period_d   = fire_ps ? 16'd0 : per_inc;
          sleeping_d = sleep_mid || fire_ps;
        end
        ises_pkg::CmdSleepDone: begin
          sleeping_d = 1'b0;
          period_d   = 16'd0;
        end
        ises_pkg::CmdSleepStart: begin
          sleeping_d = 1'b1;
        end
        ises_pkg::CmdInfer: begin
          energy_d = (energy_q > cfg_i.inference_cost) ?
                     energy_q - cfg_i.inference_cost : 10'd0;
        end
        ises_pkg::CmdExec: begin
          if (in_q.is_surgery) begin
            energy_d = (energy_q > cfg_i.surgery_cost) ?
                       energy_q - cfg_i.surgery_cost : 10'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // bit order follows the kind codes, the pulse is always due
  assign bundle_o.pend   = {fire_ps, fire_is, fire_le, fire_ls, 1'b1};
  assign bundle_o.energy = e_new;
  assign bundle_o.succ   = succ_c;
  assign bundle_o.eval   = eval_c;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      energy_q   <= ises_pkg::EnergyMax;
      sleeping_q <= 1'b0;
      low_sent_q <= 1'b0;
      idle_q     <= 16'd0;
      period_q   <= 16'd0;
      cooldown_q <= 16'd0;
    end else begin
      in_vld_q   <= in_vld_d;
      energy_q   <= energy_d;
      sleeping_q <= sleeping_d;
      low_sent_q <= low_sent_d;
      idle_q     <= idle_d;
      period_q   <= period_d;
      cooldown_q <= cooldown_d;
    end
  end

endmodule

FILE: sv/ises_serializer.sv
// holds one tick's pending results and hands them out one per cycle while the output is not stalled
module ises_serializer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   bundle_load_i,
  input  ises_pkg::ises_bundle_t bundle_i,
  output logic                   bundle_free_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output ises_pkg::ises_out_t    result_o
);

  logic [ises_pkg::KindNum-1:0] pend_q, pend_d;
  logic [9:0]                   energy_q;
  logic [4:0]                   succ_q, eval_q;
  logic                         out_vld_q, out_vld_d;
  ises_pkg::ises_out_t          out_q, out_d;

  logic                         out_free, pop;
  logic [ises_pkg::KindNum-1:0] sel, rest;
  logic [2:0]                   kind;

  assign out_free      = !out_vld_q || !stall_i;
  assign pop           = out_free && (pend_q != '0);
  assign sel           = pend_q & (~pend_q + 1'b1);
  assign rest          = pend_q & ~sel;
  assign bundle_free_o = (pend_q == '0) || (pop && (rest == '0));

  always_comb begin
    kind = 3'd0;
    for (int i = 0; i < ises_pkg::KindNum; i++) begin
      if (sel[i]) begin
        kind = 3'(i);
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (bundle_load_i) begin
      pend_d = bundle_i.pend;
    end else if (pop) begin
      pend_d = rest;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (pop) begin
      out_vld_d    = 1'b1;
      out_d.kind   = kind;
      out_d.energy = energy_q;
      out_d.last   = (rest == '0);
      // the counts only mean something on the pulse and the low-success alert
      if ((kind == ises_pkg::KindPulse) || (kind == ises_pkg::KindLowSuccess)) begin
        out_d.success_count = succ_q;
        out_d.eval_count    = eval_q;
      end else begin
        out_d.success_count = 5'd0;
        out_d.eval_count    = 5'd0;
      end
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end
  end

  assign valid_o  = out_vld_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i) begin
    if (bundle_load_i) begin
      energy_q <= bundle_i.energy;
      succ_q   <= bundle_i.succ;
      eval_q   <= bundle_i.eval;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

FILE: sv/idle_sleep_energy_supervisor.sv
// top level of the idle/sleep energy supervisor
// Event transactions (sleep complete, sleep started, inference, execution
// request) pass the input register and give no result, so they can be taken
// back to back. A tick transaction gives one to four results (pulse,
// low-success alert, low-energy alert, one sleep request); they pass the
// input register, the serializer's pending register and the output register,
// which emits one result per cycle while stall_i is low, so a tick holds the
// result path until all its results are out, while the next transaction
// already waits in the input register. Energy is kept in tenths between 0
// and 1000; registers sit on the APB port at 4*i.
module idle_sleep_energy_supervisor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  ises_pkg::ises_in_t             item_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output ises_pkg::ises_out_t            result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ises_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  ises_pkg::ises_cfg_t    cfg;
  ises_pkg::ises_bundle_t bundle;
  logic                   bundle_load, bundle_free;

  ises_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ises_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .item_i        (item_i),
    .cfg_i         (cfg),
    .bundle_free_i (bundle_free),
    .bundle_load_o (bundle_load),
    .bundle_o      (bundle)
  );

  ises_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bundle_load_i (bundle_load),
    .bundle_i      (bundle),
    .bundle_free_o (bundle_free),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .result_o      (result_o)
  );

endmodule

FILE: sv/ises_checker.sv
// port-level checks of the supervisor and their bind
module ises_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                valid_o,
  input logic                stall_i,
  input ises_pkg::ises_out_t result_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_o))
    else $error("result changed while stalled");

  a_energy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> result_o.energy <= ises_pkg::EnergyMax)
    else $error("energy above full scale");

  // alerts without counts and sleep requests carry zero counts
  a_counts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (result_o.kind == ises_pkg::KindLowEnergy ||
                result_o.kind == ises_pkg::KindIdleSleep ||
                result_o.kind == ises_pkg::KindPeriodSleep)
    |-> result_o.success_count == 5'd0 && result_o.eval_count == 5'd0)
    else $error("counts on a result that has none");

  // results of one tick follow each other without gaps in rising kind order
  a_tick_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !result_o.last
    |=> valid_o && result_o.kind > $past(result_o.kind))
    else $error("tick results out of order or interrupted");

endmodule

bind idle_sleep_energy_supervisor ises_checker u_ises_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_o  (valid_o),
  .stall_i  (stall_i),
  .result_o (result_o)
);
